@@ rtl/etpq_pkg.sv @@
// shared types, constants and compare function for the event time priority queue
package etpq_pkg;

  localparam int QDEPTH    = 64;
  localparam int IDX_W     = $clog2(QDEPTH);
  localparam int CNT_W     = $clog2(QDEPTH + 1);
  localparam int TIME_BITS = 32;
  localparam int ID_BITS   = 8;
  localparam int ENT_W     = TIME_BITS + ID_BITS;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NULL  = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic ACT_SCHED = 1'b0;
  localparam logic ACT_POP   = 1'b1;

  typedef struct packed {
    logic        action;
    logic [7:0]  unit_id;
    logic [15:0] delay;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  next_unit;
    logic [31:0] now_time;
    logic [6:0]  pending;
  } out_item_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] due;
    logic [ID_BITS-1:0]   id;
  } entry_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_ACCEPT,
    CMD_INS_RD,
    CMD_INS_MOVE,
    CMD_INS_PUT,
    CMD_POP_RD0,
    CMD_POP_RDL,
    CMD_POP_CAP,
    CMD_DN_RDL,
    CMD_DN_RDR,
    CMD_DN_MOVE,
    CMD_DN_PUT,
    CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } cmd_t;

  typedef struct packed {
    logic in_pop;
    logic in_bad;
    logic at_root;
    logic ins_up;
    logic leaf;
    logic dn_move;
    logic out_free;
  } dp_st_t;

  // earlier due time first, lower identifier on a tie
  function automatic logic entry_before(entry_t a, entry_t b);
    logic r;
    if (a.due != b.due) begin
      r = (a.due < b.due);
    end else begin
      r = (a.id < b.id);
    end
    return r;
  endfunction

endpackage

@@ rtl/etpq_ram.sv @@
// generic single write, single registered read ram
module etpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/etpq_ctrl.sv @@
// sequencer for heap insert and pop
module etpq_ctrl import etpq_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  input  dp_st_t st_i,
  output cmd_t   cmd_o,
  output logic   in_stall_o
);

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_INS_RD  = 10'b0000000010,
    S_INS_CMP = 10'b0000000100,
    S_POP_RD0 = 10'b0000001000,
    S_POP_RDL = 10'b0000010000,
    S_POP_CAP = 10'b0000100000,
    S_DN_RDL  = 10'b0001000000,
    S_DN_RDR  = 10'b0010000000,
    S_DN_CMP  = 10'b0100000000,
    S_FIN     = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // next state and command
  always_comb begin
    state_d    = state_q;
    cmd_o.op   = CMD_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_ACCEPT;
          if (st_i.in_bad)      state_d = S_FIN;
          else if (st_i.in_pop) state_d = S_POP_RD0;
          else                  state_d = S_INS_RD;
        end
      end
      S_INS_RD: begin
        if (st_i.at_root) begin
          cmd_o.op = CMD_INS_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = CMD_INS_RD;
          state_d  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (st_i.ins_up) begin
          cmd_o.op = CMD_INS_MOVE;
          state_d  = S_INS_RD;
        end else begin
          cmd_o.op = CMD_INS_PUT;
          state_d  = S_FIN;
        end
      end
      S_POP_RD0: begin
        cmd_o.op = CMD_POP_RD0;
        state_d  = S_POP_RDL;
      end
      S_POP_RDL: begin
        cmd_o.op = CMD_POP_RDL;
        state_d  = S_POP_CAP;
      end
      S_POP_CAP: begin
        cmd_o.op = CMD_POP_CAP;
        state_d  = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (st_i.leaf) begin
          cmd_o.op = CMD_DN_PUT;
          state_d  = S_FIN;
        end else begin
          cmd_o.op = CMD_DN_RDL;
          state_d  = S_DN_RDR;
        end
      end
      S_DN_RDR: begin
        cmd_o.op = CMD_DN_RDR;
        state_d  = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (st_i.dn_move) begin
          cmd_o.op = CMD_DN_MOVE;
          state_d  = S_DN_RDL;
        end else begin
          cmd_o.op = CMD_DN_PUT;
          state_d  = S_FIN;
        end
      end
      S_FIN: begin
        if (st_i.out_free) begin
          cmd_o.op = CMD_FIN;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

@@ rtl/etpq_dp.sv @@
// heap datapath: event store, count, current time and result register
module etpq_dp import etpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_data_i,
  input  cmd_t      cmd_i,
  output dp_st_t    st_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  entry_t               ent_q, ent_d;
  entry_t               best_q, best_d;
  logic [1:0]           res_st_q, res_st_d;
  logic [ID_BITS-1:0]   res_id_q, res_id_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_q, out_d;

  logic                 we, re;
  logic [IDX_W-1:0]     waddr, raddr;
  entry_t               wdata, rdata;
  logic [ENT_W-1:0]     rdata_raw;

  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] due_sat;
  logic [1:0]           code;
  logic [IDX_W-1:0]     parent;
  logic [CNT_W-1:0]     lft, rgt;
  logic                 has_r, pick_r;
  entry_t               child;
  logic [IDX_W-1:0]     cidx;

  etpq_ram #(.WIDTH(ENT_W), .DEPTH(QDEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  // saturating due time and item status
  always_comb begin
    sum     = {1'b0, now_q} + {{(TIME_BITS-15){1'b0}}, in_data_i.delay};
    due_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
    if (in_data_i.action == ACT_POP) begin
      code = (cnt_q == '0) ? ST_EMPTY : ST_OK;
    end else if (in_data_i.unit_id[ID_BITS-1:0] == '0) begin
      code = ST_NULL;
    end else if (cnt_q == CNT_W'(QDEPTH)) begin
      code = ST_FULL;
    end else begin
      code = ST_OK;
    end
  end

  // heap index arithmetic and child selection
  always_comb begin
    parent = (idx_q - IDX_W'(1)) >> 1;
    lft    = {idx_q, 1'b1};
    rgt    = lft + CNT_W'(1);
    has_r  = (rgt < cnt_q);
    pick_r = has_r && entry_before(rdata, best_q);
    child  = pick_r ? rdata : best_q;
    cidx   = pick_r ? rgt[IDX_W-1:0] : lft[IDX_W-1:0];
  end

  // status to controller
  always_comb begin
    st_o.in_pop   = (in_data_i.action == ACT_POP);
    st_o.in_bad   = (code != ST_OK);
    st_o.at_root  = (idx_q == '0);
    st_o.ins_up   = entry_before(ent_q, rdata);
    st_o.leaf     = (lft >= cnt_q);
    st_o.dn_move  = entry_before(child, ent_q);
    st_o.out_free = !out_valid_q || !out_stall_i;
  end

  // command decode
  always_comb begin
    cnt_d       = cnt_q;
    now_d       = now_q;
    idx_d       = idx_q;
    ent_d       = ent_q;
    best_d      = best_q;
    res_st_d    = res_st_q;
    res_id_d    = res_id_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = idx_q;
    wdata       = ent_q;
    raddr       = '0;
    unique case (cmd_i.op)
      CMD_NONE: ;
      CMD_ACCEPT: begin
        ent_d.due = due_sat;
        ent_d.id  = in_data_i.unit_id[ID_BITS-1:0];
        idx_d     = cnt_q[IDX_W-1:0];
        res_st_d  = code;
        res_id_d  = '0;
      end
      CMD_INS_RD: begin
        re    = 1'b1;
        raddr = parent;
      end
      CMD_INS_MOVE: begin
        we    = 1'b1;
        wdata = rdata;
        idx_d = parent;
      end
      CMD_INS_PUT: begin
        we    = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
      CMD_POP_RD0: begin
        re    = 1'b1;
        raddr = '0;
      end
      CMD_POP_RDL: begin
        re       = 1'b1;
        raddr    = IDX_W'(cnt_q - CNT_W'(1));
        res_id_d = rdata.id;
        now_d    = rdata.due;
        cnt_d    = cnt_q - CNT_W'(1);
        idx_d    = '0;
      end
      CMD_POP_CAP: ent_d = rdata;
      CMD_DN_RDL: begin
        re    = 1'b1;
        raddr = lft[IDX_W-1:0];
      end
      CMD_DN_RDR: begin
        best_d = rdata;
        re     = 1'b1;
        raddr  = rgt[IDX_W-1:0];
      end
      CMD_DN_MOVE: begin
        we    = 1'b1;
        wdata = child;
        idx_d = cidx;
      end
      CMD_DN_PUT: we = 1'b1;
      CMD_FIN: begin
        out_valid_d       = 1'b1;
        out_d.status      = res_st_q;
        out_d.next_unit   = 8'(res_id_q);
        out_d.now_time    = 32'(now_q);
        out_d.pending     = 7'(cnt_q);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    ent_q    <= ent_d;
    best_q   <= best_d;
    res_st_q <= res_st_d;
    res_id_q <= res_id_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QDEPTH))
    else $error("event count beyond store depth");
  a_put_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_INS_PUT) |-> (cnt_q < CNT_W'(QDEPTH)))
    else $error("insert into full store");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_POP_RDL) |-> (cnt_q != '0))
    else $error("pop from empty store");
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == CMD_FIN) |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

@@ rtl/event_time_priority_queue_top.sv @@
// top level of the event time priority queue
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | in_data_i  (in_item_t)
//  out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
// one item at a time; a schedule climbs the heap one level per parent read and compare,
// then writes the new entry; a pop reads the root and the last entry, then sinks it
// one level per read of both children and compare, then writes it back, each read
// going through the single registered read port of the event store memory.
// rejected items skip the heap. reset clears count, time and valid; the store
// needs no clearing. a stalled output holds its item; the next item is taken
// meanwhile and waits finished until the output register frees.
module event_time_priority_queue_top import etpq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  cmd_t   cmd;
  dp_st_t st;

  // controller
  etpq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .st_i       (st),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // datapath
  etpq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
